// ===== hw/rtl/bir_pkg.sv =====
`default_nettype none
package bir_pkg;
  localparam int PIX_W = 24;
  localparam int CH_W = 8;
  localparam int COORD_W = 12;
  localparam int SW_W = 10;
  localparam int DW_W = 13;
  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_REQUEST = 1'b1;
endpackage
`default_nettype wire

// ===== hw/rtl/bilinear_image_resampler_core.sv =====
`default_nettype none
// Bilinear RGB resampler with corner-aligned scaling.
// Slave channel s_axis carries writes (store one source pixel, no result)
// and requests (one destination pixel, one result on m_axis).
// The source frame lives in four banks split by row and column parity, so
// the four neighbors of any point come out of the banks in one read. Writes travel
// down the pipeline beside the requests and reach the banks at the read
// stage, so every request sees exactly the writes transferred before it.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data).
// One item is taken every clock while the output is not stalled. A request's
// result appears on m_axis after two setup stages, a pipelined divider per
// axis with one quotient bit per stage (NW = 12 + log2 of the larger maximum
// source size + FRACTION_BITS quotient bits), the bank read, two multiply
// stages per channel lane and the output register.
// The whole pipeline moves only while the output register is empty or being
// taken, so a stalled receiver holds everything, and s_axis_tready drops with it.
// Reset clears the registers to their defaults and the valid flags; the
// frame store is not cleared and must be written before it is read.
module bilinear_image_resampler_core #(
  parameter int MAX_SOURCE_WIDTH = 512,
  parameter int MAX_SOURCE_HEIGHT = 512,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // opcode[0], row[12:1], column[24:13], red_in[32:25], green_in[40:33],
  // blue_in[48:41], zero fill
  input  wire logic [55:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output      logic [23:0] m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import bir_pkg::*;
  localparam int XW = $clog2(MAX_SOURCE_WIDTH);
  localparam int YW = $clog2(MAX_SOURCE_HEIGHT);
  localparam int HXW = XW - 1;
  localparam int HYW = YW - 1;
  localparam int NWX = COORD_W + XW + FRACTION_BITS;
  localparam int NWY = COORD_W + YW + FRACTION_BITS;
  localparam int NW = (NWX > NWY) ? NWX : NWY;
  localparam int WTW = YW + XW + PIX_W;

  logic [SW_W-1:0] source_width, source_height;
  logic [DW_W-1:0] dest_width, dest_height;
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= SW_W'(512);
      source_height <= SW_W'(512);
      dest_width <= DW_W'(384);
      dest_height <= DW_W'(384);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_W: source_width <= cfg_data[SW_W-1:0];
        REG_SRC_H: source_height <= cfg_data[SW_W-1:0];
        REG_DST_W: dest_width <= cfg_data;
        REG_DST_H: dest_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes.
  logic [12:0] sw, sh, dw, dh;
  always_comb begin
    sw = (source_width == 0) ? 13'd1 :
         ({3'd0, source_width} > 13'(MAX_SOURCE_WIDTH)) ? 13'(MAX_SOURCE_WIDTH) :
         {3'd0, source_width};
    sh = (source_height == 0) ? 13'd1 :
         ({3'd0, source_height} > 13'(MAX_SOURCE_HEIGHT)) ? 13'(MAX_SOURCE_HEIGHT) :
         {3'd0, source_height};
    dw = (dest_width == 0) ? 13'd1 : dest_width;
    dh = (dest_height == 0) ? 13'd1 : dest_height;
  end

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  logic acc;
  assign acc = s_axis_tvalid && adv;

  logic op;
  logic [COORD_W-1:0] in_row, in_col;
  assign op = s_axis_tdata[0];
  assign in_row = s_axis_tdata[12:1];
  assign in_col = s_axis_tdata[24:13];

  // Write path.
  logic [COORD_W-1:0] wrow, wcol;
  logic wok;
  assign wrow = in_row;
  assign wcol = in_col;
  assign wok = acc && (op == OP_WRITE) && ({1'b0, wrow} < 13'(MAX_SOURCE_HEIGHT)) &&
               ({1'b0, wcol} < 13'(MAX_SOURCE_WIDTH));
  logic [PIX_W-1:0] wpix;
  assign wpix = {s_axis_tdata[32:25], s_axis_tdata[40:33], s_axis_tdata[48:41]};

  // Stage 1: clamp; the multiply follows in stage 2.
  logic s1_v;
  logic [12:0] s1_numx, s1_numy;
  logic [12:0] s1_dx, s1_dy;
  logic s1_onex, s1_oney;
  logic s1_wv;
  logic [YW-1:0] s1_wrow;
  logic [XW-1:0] s1_wcol;
  logic [PIX_W-1:0] s1_wpix;
  logic [12:0] cr, cc;
  always_comb begin
    cr = ({1'b0, in_row} >= dh) ? dh - 13'd1 : {1'b0, in_row};
    cc = ({1'b0, in_col} >= dw) ? dw - 13'd1 : {1'b0, in_col};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s1_wv <= 1'b0;
    end else if (adv) begin
      s1_v <= acc && (op == OP_REQUEST);
      s1_wv <= wok;
    end
    if (adv) begin
      s1_numx <= cc;
      s1_numy <= cr;
      s1_dx <= (dw <= 13'd1) ? 13'd1 : dw - 13'd1;
      s1_dy <= (dh <= 13'd1) ? 13'd1 : dh - 13'd1;
      s1_onex <= dw <= 13'd1;
      s1_oney <= dh <= 13'd1;
      s1_wrow <= wrow[YW-1:0];
      s1_wcol <= wcol[XW-1:0];
      s1_wpix <= wpix;
    end
  end
  logic [NW-1:0] s2_nx, s2_ny;
  logic [12:0] s2_dx, s2_dy;
  logic s2_v;
  logic [12:0] s2_sw, s2_sh;
  logic s2_wv;
  logic [YW-1:0] s2_wrow;
  logic [XW-1:0] s2_wcol;
  logic [PIX_W-1:0] s2_wpix;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s2_wv <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
      s2_wv <= s1_wv;
    end
    if (adv) begin
      s2_nx <= s1_onex ? '0 :
               (NW'(s1_numx) * NW'(sw - 13'd1)) << FRACTION_BITS;
      s2_ny <= s1_oney ? '0 :
               (NW'(s1_numy) * NW'(sh - 13'd1)) << FRACTION_BITS;
      s2_dx <= s1_dx;
      s2_dy <= s1_dy;
      s2_sw <= sw;
      s2_sh <= sh;
      s2_wrow <= s1_wrow;
      s2_wcol <= s1_wcol;
      s2_wpix <= s1_wpix;
    end
  end

  logic [NW-1:0] qx, qy;
  logic [25:0] tag_o;
  logic [WTW-1:0] wtag;
  bir_divider #(.NW(NW), .DW(13), .TW(26)) u_divx (
    .clk(clk), .en(adv), .num(s2_nx), .den(s2_dx),
    .tag_in({s2_sw, s2_sh}), .quo(qx), .tag_out(tag_o)
  );
  bir_divider #(.NW(NW), .DW(13), .TW(WTW)) u_divy (
    .clk(clk), .en(adv), .num(s2_ny), .den(s2_dy),
    .tag_in({s2_wrow, s2_wcol, s2_wpix}), .quo(qy), .tag_out(wtag)
  );

  // Valid flags ride beside the divider so they clear at reset.
  logic [NW-1:0] rv_pipe, wv_pipe;
  always_ff @(posedge clk) begin
    if (rst) begin
      rv_pipe <= '0;
      wv_pipe <= '0;
    end else if (adv) begin
      rv_pipe <= {rv_pipe[NW-2:0], s2_v};
      wv_pipe <= {wv_pipe[NW-2:0], s2_wv};
    end
  end

  logic d_v, d_wv;
  logic [12:0] d_sw, d_sh;
  logic [YW-1:0] d_wrow;
  logic [XW-1:0] d_wcol;
  logic [PIX_W-1:0] d_wpix;
  assign d_v = rv_pipe[NW-1];
  assign d_wv = wv_pipe[NW-1];
  assign d_sw = tag_o[25:13];
  assign d_sh = tag_o[12:0];
  assign d_wrow = wtag[WTW-1 -: YW];
  assign d_wcol = wtag[PIX_W+XW-1 -: XW];
  assign d_wpix = wtag[PIX_W-1:0];

  // Stage 3: integer parts, neighbors, bank addresses.
  logic [NW-1:0] ix, iy;
  logic [12:0] x0, y0, x1, y1;
  always_comb begin
    ix = qx >> FRACTION_BITS;
    iy = qy >> FRACTION_BITS;
    x0 = (ix > NW'(d_sw - 13'd1)) ? d_sw - 13'd1 : ix[12:0];
    y0 = (iy > NW'(d_sh - 13'd1)) ? d_sh - 13'd1 : iy[12:0];
    x1 = (x0 + 13'd1 < d_sw) ? x0 + 13'd1 : d_sw - 13'd1;
    y1 = (y0 + 13'd1 < d_sh) ? y0 + 13'd1 : d_sh - 13'd1;
  end
  // Bank (ry,rx): entries with row parity ry and column parity rx.
  logic [HYW-1:0] rrow [2];
  logic [HXW-1:0] rcol [2];
  logic [12:0] ye, yo, xe, xo;
  always_comb begin
    ye = y0[0] ? y1 : y0;
    yo = y0[0] ? y0 : y1;
    xe = x0[0] ? x1 : x0;
    xo = x0[0] ? x0 : x1;
    rrow[0] = ye[YW-1:1];
    rrow[1] = yo[YW-1:1];
    rcol[0] = xe[XW-1:1];
    rcol[1] = xo[XW-1:1];
  end
  logic r_v, r_px, r_py, r_ysame, r_xsame;
  logic [FRACTION_BITS-1:0] r_fx, r_fy;
  always_ff @(posedge clk) begin
    if (rst) r_v <= 1'b0;
    else if (adv) r_v <= d_v;
    if (adv) begin
      r_px <= x0[0];
      r_py <= y0[0];
      r_xsame <= x0 == x1;
      r_ysame <= y0 == y1;
      r_fx <= qx[FRACTION_BITS-1:0];
      r_fy <= qy[FRACTION_BITS-1:0];
    end
  end

  logic [PIX_W-1:0] bank_q [4];
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [HYW+HXW-1:0] wa, ra;
    assign wa = {d_wrow[YW-1:1], d_wcol[XW-1:1]};
    assign ra = {rrow[b/2], rcol[b%2]};
    bir_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT / 4)) u_ram (
      .clk(clk),
      .we(adv && d_wv && (d_wrow[0] == 1'((b / 2) % 2)) && (d_wcol[0] == 1'(b % 2))),
      .waddr(wa), .wdata(d_wpix), .re(adv), .raddr(ra), .rdata(bank_q[b])
    );
  end

  // Route banks to neighbors.
  logic [PIX_W-1:0] p00, p01, p10, p11;
  always_comb begin
    p00 = bank_q[{r_py, r_px}];
    p01 = r_xsame ? p00 : bank_q[{r_py, ~r_px}];
    p10 = r_ysame ? p00 : bank_q[{~r_py, r_px}];
    p11 = r_ysame ? p01 : (r_xsame ? p10 : bank_q[{~r_py, ~r_px}]);
  end

  logic [7:0] ch [3];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    bir_lane #(.FB(FRACTION_BITS)) u_lane (
      .clk(clk), .en(adv),
      .a(p00[23-8*c -: 8]), .b(p01[23-8*c -: 8]),
      .c(p10[23-8*c -: 8]), .d(p11[23-8*c -: 8]),
      .fx(r_fx), .fy(r_fy), .result(ch[c])
    );
  end
  logic l1_v, l2_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_v <= 1'b0;
      l2_v <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      l1_v <= r_v;
      l2_v <= l1_v;
      m_axis_tvalid <= l2_v;
    end
    if (adv) m_axis_tdata <= {ch[2], ch[1], ch[0]};
  end
  logic unused;
  assign unused = ^{qx[NW-1:FRACTION_BITS], qy[NW-1:FRACTION_BITS],
                    s_axis_tdata[55:49],
                    y0[12:YW], y1[12:YW], x0[12:XW], x1[12:XW], ye[0], yo[0], xe[0], xo[0]};
endmodule
`default_nettype wire

// ===== hw/rtl/bir_ram.sv =====
`default_nettype none
module bir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bir_divider.sv =====
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage.
module bir_divider #(
  parameter int NW = 33,
  parameter int DW = 13,
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [TW-1:0] tag_in,
  output      logic [NW-1:0] quo,
  output      logic [TW-1:0] tag_out
);
  logic [NW-1:0] q   [NW+1];
  logic [DW-1:0] rem [NW+1];
  logic [DW-1:0] d   [NW+1];
  logic [TW-1:0] tg  [NW+1];
  assign q[0] = num;
  assign rem[0] = '0;
  assign d[0] = den;
  assign tg[0] = tag_in;
  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    assign trial = {rem[s], q[s][NW-1]};
    assign diff = trial - {1'b0, d[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DW]) begin
          rem[s+1] <= diff[DW-1:0];
          q[s+1] <= {q[s][NW-2:0], 1'b1};
        end else begin
          rem[s+1] <= trial[DW-1:0];
          q[s+1] <= {q[s][NW-2:0], 1'b0};
        end
        d[s+1] <= d[s];
        tg[s+1] <= tg[s];
      end
    end
  end
  assign quo = q[NW];
  assign tag_out = tg[NW];
endmodule
`default_nettype wire

// ===== hw/rtl/bir_lane.sv =====
`default_nettype none
// One color channel: bilinear blend of four neighbors, two multiply stages.
module bir_lane #(
  parameter int FB = 8
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [7:0]   a,
  input  wire logic [7:0]   b,
  input  wire logic [7:0]   c,
  input  wire logic [7:0]   d,
  input  wire logic [FB-1:0] fx,
  input  wire logic [FB-1:0] fy,
  output      logic [7:0]   result
);
  logic [FB:0] wx0, wy0;
  logic [8+FB:0] top, bot;
  logic [FB:0] fy_q, wy0_q;
  logic [9+2*FB:0] sum;
  logic [9+2*FB:0] sh;
  assign wx0 = (FB+1)'(1 << FB) - {1'b0, fx};
  assign wy0 = (FB+1)'(1 << FB) - {1'b0, fy};
  always_ff @(posedge clk) begin
    if (en) begin
      top <= (9+FB)'(a) * (9+FB)'(wx0) + (9+FB)'(b) * (9+FB)'(fx);
      bot <= (9+FB)'(c) * (9+FB)'(wx0) + (9+FB)'(d) * (9+FB)'(fx);
      fy_q <= {1'b0, fy};
      wy0_q <= wy0;
      sum <= (10+2*FB)'(top) * (10+2*FB)'(wy0_q) + (10+2*FB)'(bot) * (10+2*FB)'(fy_q);
    end
  end
  assign sh = sum >> (2 * FB);
  assign result = (sh > 255) ? 8'hFF : sh[7:0];
endmodule
`default_nettype wire

// ===== tb/bilinear_image_resampler_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module bilinear_image_resampler_core_tb;
  import bir_pkg::*;

  localparam int STORE_COLS = 512;
  localparam int STORE_ROWS = 512;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 20000;

  // Golden resampler: its own copy of the frame store and size registers,
  // plus the queue of pixels the block still owes us.
  class resample_board;
    bit [23:0] pixels [STORE_COLS*STORE_ROWS];
    int unsigned src_w, src_h, dst_w, dst_h;
    logic [23:0] owed [$];
    int unsigned errors, checked, stored;

    function new();
      src_w = 512; src_h = 512; dst_w = 384; dst_h = 384;
    endfunction

    function void set_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        REG_SRC_W: src_w = val[9:0];
        REG_SRC_H: src_h = val[9:0];
        REG_DST_W: dst_w = val;
        REG_DST_H: dst_h = val;
        default: ;
      endcase
    endfunction

    function int unsigned clip_size(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function longint unsigned axis_pos(int unsigned d, int unsigned src, int unsigned dst);
      longint unsigned num;
      if (dst <= 1) return 0;
      num = longint'(d) * longint'(src - 1);
      return (num << 8) / longint'(dst - 1);
    endfunction

    // Source corners and Q0.8 fractions for one destination point.
    function void corners(input int unsigned row, col,
                          output int unsigned y0, x0, y1, x1,
                          output longint unsigned fy, fx);
      int unsigned sw, sh, dw, dh;
      longint unsigned py, px;
      sw = clip_size(src_w, STORE_COLS);
      sh = clip_size(src_h, STORE_ROWS);
      dw = clip_size(dst_w, 8191);
      dh = clip_size(dst_h, 8191);
      if (row >= dh) row = dh - 1;
      if (col >= dw) col = dw - 1;
      py = axis_pos(row, sh, dh);
      px = axis_pos(col, sw, dw);
      y0 = 32'(py >> 8);
      x0 = 32'(px >> 8);
      fy = py & 8'hFF;
      fx = px & 8'hFF;
      if (y0 > sh - 1) y0 = sh - 1;
      if (x0 > sw - 1) x0 = sw - 1;
      y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
      x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
    endfunction

    function void note_transfer(logic [55:0] d);
      int unsigned row, col, y0, x0, y1, x1;
      longint unsigned fy, fx, a, b, c, e, sum;
      bit [23:0] p00, p01, p10, p11;
      logic [23:0] res;
      row = d[12:1];
      col = d[24:13];
      if (d[0] == OP_WRITE) begin
        if (row < STORE_ROWS && col < STORE_COLS) begin
          pixels[row*STORE_COLS + col] = {d[32:25], d[40:33], d[48:41]};
          stored++;
        end
        return;
      end
      corners(row, col, y0, x0, y1, x1, fy, fx);
      p00 = pixels[y0*STORE_COLS + x0];
      p01 = pixels[y0*STORE_COLS + x1];
      p10 = pixels[y1*STORE_COLS + x0];
      p11 = pixels[y1*STORE_COLS + x1];
      for (int ch = 0; ch < 3; ch++) begin
        a = (p00 >> (16 - 8*ch)) & 8'hFF;
        b = (p01 >> (16 - 8*ch)) & 8'hFF;
        c = (p10 >> (16 - 8*ch)) & 8'hFF;
        e = (p11 >> (16 - 8*ch)) & 8'hFF;
        sum = a*(256-fx)*(256-fy) + b*fx*(256-fy) + c*(256-fx)*fy + e*fx*fy;
        sum = sum >> 16;
        if (sum > 255) sum = 255;
        res[8*ch +: 8] = sum[7:0];
      end
      owed = {owed, res};
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [23:0] d);
      logic [23:0] want;
      string names [3];
      names = '{"red", "green", "blue"};
      if (owed.size() == 0) begin
        report("unexpected pixel", d[7:0], 8'd0);
        return;
      end
      want = owed.pop_front();
      checked++;
      for (int ch = 0; ch < 3; ch++)
        if (d[8*ch +: 8] !== want[8*ch +: 8])
          report(names[ch], d[8*ch +: 8], want[8*ch +: 8]);
    endtask
  endclass

  logic clk, rst;
  logic s_tvalid, m_tready, cfg_we;
  logic [55:0] s_tdata;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;
  wire logic s_tready, m_tvalid;
  wire logic [23:0] m_tdata;

  resample_board board;
  bit filled [STORE_COLS*STORE_ROWS];
  bit idle_on;
  bit hold_now;
  int unsigned stall_count;
  int unsigned requests_sent, phases_run;

  bilinear_image_resampler_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial board = new();

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_transfer(s_tdata);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
    end
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("Watchdog expired with %0d pixels outstanding", board.owed.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold when asked.
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_now) begin
        hold_now = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic push(input logic op, input int unsigned row, col,
                      input logic [7:0] r, g, b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, b, g, r, col[11:0], row[11:0], op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_WRITE && row < STORE_ROWS && col < STORE_COLS)
      filled[row*STORE_COLS + col] = 1'b1;
  endtask

  task automatic store_pixel(int unsigned row, col);
    push(OP_WRITE, row, col, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)));
  endtask

  // Writes whatever corners are still empty, then asks for the pixel.
  task automatic request(int unsigned row, col);
    int unsigned y0, x0, y1, x1;
    longint unsigned fy, fx;
    board.corners(row, col, y0, x0, y1, x1, fy, fx);
    if (!filled[y0*STORE_COLS + x0]) store_pixel(y0, x0);
    if (!filled[y0*STORE_COLS + x1]) store_pixel(y0, x1);
    if (!filled[y1*STORE_COLS + x0]) store_pixel(y1, x0);
    if (!filled[y1*STORE_COLS + x1]) store_pixel(y1, x1);
    push(OP_REQUEST, row, col, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)));
    requests_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  // Writes without a result may still be in flight, so wait out the
  // pipeline before touching the size registers.
  task automatic set_sizes(int unsigned sw, sh, dw, dh);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= (i == 0) ? sw[12:0] : (i == 1) ? sh[12:0] : (i == 2) ? dw[12:0] : dh[12:0];
      @(posedge clk);
      board.set_reg(i[1:0], (i == 0) ? sw[12:0] : (i == 1) ? sh[12:0] :
                            (i == 2) ? dw[12:0] : dh[12:0]);
    end
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  initial begin
    int unsigned sw, sh, dw, dh, sel, row, col, ew, eh, edw, edh;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_SRC_W;
    cfg_data <= '0;
    idle_on = 1'b0;
    hold_now = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a 3x2 source blown up to 5x4, corners, clamps and extremes.
    set_sizes(3, 2, 5, 4);
    push(OP_WRITE, 0, 0, 8'hFF, 8'h00, 8'hAA);
    push(OP_WRITE, 0, 1, 8'h00, 8'hFF, 8'h55);
    push(OP_WRITE, 0, 2, 8'hFF, 8'hFF, 8'hFF);
    push(OP_WRITE, 1, 0, 8'h00, 8'h00, 8'h00);
    push(OP_WRITE, 1, 1, 8'h80, 8'h7F, 8'h01);
    push(OP_WRITE, 1, 2, 8'hFE, 8'h01, 8'hFF);
    request(0, 0);
    request(3, 4);
    request(1, 1);
    request(2, 3);
    request(4095, 4095);
    request(0, 4095);
    // A write far outside the store must leave it untouched.
    push(OP_WRITE, 4095, 4095, 8'h12, 8'h34, 8'h56);
    push(OP_WRITE, 512, 0, 8'h12, 8'h34, 8'h56);
    request(1, 2);
    // Zero sizes act as one; a destination of one maps everything to 0.
    set_sizes(0, 1, 1, 0);
    request(0, 0);
    request(4095, 4095);
    // Oversized source register acts as the store size.
    set_sizes(1023, 1023, 8191, 4096);
    request(8191 % 4096, 4095);
    request(2048, 1);

    idle_on = 1'b1;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin sw = 512; sh = 1; dw = 4096; dh = 1; end
        1: begin sw = 1; sh = 512; dw = 1; dh = 8191; end
        2: begin sw = 1023; sh = 2; dw = 700; dh = 3; end
        default: begin
          sw = $urandom_range(0, 12);
          sh = $urandom_range(0, 12);
          dw = $urandom_range(0, 40);
          dh = $urandom_range(0, 40);
        end
      endcase
      set_sizes(sw, sh, dw, dh);
      if (ph == 9) idle_on = 1'b0;
      ew = board.clip_size(board.src_w, STORE_COLS);
      eh = board.clip_size(board.src_h, STORE_ROWS);
      edw = board.clip_size(board.dst_w, 8191);
      edh = board.clip_size(board.dst_h, 8191);
      if (ph == 4) hold_now = 1'b1;
      for (int n = 0; n < 80; n++) begin
        if (ph == 5 && n == 40) drain();
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
          row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, edh > 4096 ? 4095 : edh - 1);
          col = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, edw > 4096 ? 4095 : edw - 1);
          request(row, col);
        end else if (sel <= 8) begin
          store_pixel($urandom_range(0, eh - 1), $urandom_range(0, ew - 1));
        end else begin
          store_pixel($urandom_range(STORE_ROWS, 4095), $urandom_range(0, 4095));
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (board.owed.size() != 0) begin
      void'(board.owed.pop_front());
      board.report("missing pixel", 8'd0, 8'd0);
    end
    $display("Covered %0d size settings, %0d pixel stores and %0d resample requests,",
             phases_run, board.stored, requests_sent);
    $display("with clamped coordinates, degenerate sizes and output back-pressure.");
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
